// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

// ===== src/cpu65_pkg.sv =====
// Shared types, command codes and flag positions of the 6502 execute unit.
// Depends on nothing.
package cpu65_pkg;
  localparam logic [5:0] CMD_ADC = 6'd0,  CMD_AND = 6'd1,  CMD_ASL = 6'd2,  CMD_BCC = 6'd3;
  localparam logic [5:0] CMD_BCS = 6'd4,  CMD_BEQ = 6'd5,  CMD_BIT = 6'd6,  CMD_BMI = 6'd7;
  localparam logic [5:0] CMD_BNE = 6'd8,  CMD_BPL = 6'd9,  CMD_BRK = 6'd10, CMD_BVC = 6'd11;
  localparam logic [5:0] CMD_BVS = 6'd12, CMD_CLC = 6'd13, CMD_CLD = 6'd14, CMD_CLI = 6'd15;
  localparam logic [5:0] CMD_CLV = 6'd16, CMD_CMP = 6'd17, CMD_CPX = 6'd18, CMD_CPY = 6'd19;
  localparam logic [5:0] CMD_DEC = 6'd20, CMD_DEX = 6'd21, CMD_DEY = 6'd22, CMD_EOR = 6'd23;
  localparam logic [5:0] CMD_INC = 6'd24, CMD_INX = 6'd25, CMD_INY = 6'd26, CMD_JMP = 6'd27;
  localparam logic [5:0] CMD_JSR = 6'd28, CMD_LDA = 6'd29, CMD_LDX = 6'd30, CMD_LDY = 6'd31;
  localparam logic [5:0] CMD_LSR = 6'd32, CMD_NOP = 6'd33, CMD_ORA = 6'd34, CMD_PHA = 6'd35;
  localparam logic [5:0] CMD_PHP = 6'd36, CMD_PLA = 6'd37, CMD_PLP = 6'd38, CMD_ROL = 6'd39;
  localparam logic [5:0] CMD_ROR = 6'd40, CMD_RTI = 6'd41, CMD_RTS = 6'd42, CMD_SBC = 6'd43;
  localparam logic [5:0] CMD_SEC = 6'd44, CMD_SED = 6'd45, CMD_SEI = 6'd46, CMD_STA = 6'd47;
  localparam logic [5:0] CMD_STX = 6'd48, CMD_STY = 6'd49, CMD_TAX = 6'd50, CMD_TAY = 6'd51;
  localparam logic [5:0] CMD_TSX = 6'd52, CMD_TXA = 6'd53, CMD_TXS = 6'd54, CMD_TYA = 6'd55;

  localparam int F_C = 0, F_Z = 1, F_I = 2, F_D = 3, F_B = 4, F_U = 5, F_V = 6, F_N = 7;
  localparam logic [7:0] SP_RESET = 8'hFD;
  localparam logic [7:0] STACK_PAGE_HI = 8'h01;
  localparam int STACK_DEPTH = 256;

  typedef enum logic {ST_IDLE, ST_RUN} seq_state_t;

  typedef struct packed {
    logic [5:0]        cmd;
    logic [7:0]        opcode;
    logic [7:0]        operand;
    logic [15:0]       eff_addr;
    logic signed [7:0] rel_offset;
    logic              acc_mode;
    logic [15:0]       pc_next;
  } item_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] p;
  } regs_t;

  // Bytes pulled from the stack: first, second and the one on the read port.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] rd;
  } pulled_t;

  typedef struct packed {
    logic        page_penalty_ok;
    logic [1:0]  extra_cycles;
    logic [7:0]  status_out;
    logic [7:0]  sp_out;
    logic [7:0]  y_out;
    logic [7:0]  x_out;
    logic [7:0]  acc_out;
    logic [15:0] pc_out;
    logic [7:0]  write_data;
    logic [15:0] write_addr;
    logic        write_enable;
  } result_t;
endpackage

// ===== src/cpu65_stack_ram.sv =====
// Stack page store: 256 x 8 single-port RAM with registered read.
// Per-entry valid bits cleared at reset make unwritten entries read as zero.
// Depends on cpu65_pkg.
module cpu65_stack_ram
  import cpu65_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       we,
  input  logic [7:0] addr,
  input  logic [7:0] wdata,
  output logic [7:0] rdata
);
  logic [7:0] mem [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] valid_r;
  logic [7:0] q_r;
  logic qv_r;

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end
    if (en && !we) begin
      q_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      qv_r    <= 1'b0;
    end else if (en) begin
      if (we) begin
        valid_r[addr] <= 1'b1;
      end else begin
        qv_r <= valid_r[addr];
      end
    end
  end

  assign rdata = qv_r ? q_r : 8'h00;
endmodule

// ===== src/cpu65_exec.sv =====
// Instruction datapath: next registers and result fields for one instruction.
// Depends on cpu65_pkg.
module cpu65_exec
  import cpu65_pkg::*;
(
  input  item_t       it,
  input  regs_t       r,
  input  pulled_t     pl,
  input  logic [15:0] break_vector,
  output regs_t       n,
  output result_t     res
);
  logic [7:0] m, mm, src, t, nz_v, cmp_r;
  logic [8:0] sum9, diff9;
  logic nz_en, branch, cond;
  logic [15:0] ret, target;

  always_comb begin
    m      = it.operand;
    mm     = (it.cmd == CMD_SBC) ? ~m : m;
    src    = it.acc_mode ? r.a : m;
    sum9   = {1'b0, r.a} + {1'b0, mm} + {8'h00, r.p[F_C]};
    cmp_r  = (it.cmd == CMD_CPX) ? r.x : ((it.cmd == CMD_CPY) ? r.y : r.a);
    diff9  = {1'b0, cmp_r} - {1'b0, m};
    ret    = it.pc_next + 16'd1;
    target = it.pc_next + {{8{it.rel_offset[7]}}, it.rel_offset};
    n      = r;
    res    = '0;
    res.pc_out = it.pc_next;
    nz_en  = 1'b0;
    nz_v   = 8'h00;
    t      = 8'h00;
    branch = 1'b0;
    cond   = 1'b0;
    case (it.cmd)
      CMD_ADC, CMD_SBC: begin
        n.p[F_C] = sum9[8];
        n.p[F_V] = ~(r.a[7] ^ mm[7]) & (r.a[7] ^ sum9[7]);
        n.a = sum9[7:0];
        nz_en = 1'b1; nz_v = sum9[7:0];
        res.page_penalty_ok = 1'b1;
      end
      CMD_AND, CMD_EOR, CMD_ORA: begin
        n.a = (it.cmd == CMD_AND) ? (r.a & m) : ((it.cmd == CMD_EOR) ? (r.a ^ m) : (r.a | m));
        nz_en = 1'b1; nz_v = n.a;
        res.page_penalty_ok = 1'b1;
      end
      CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR: begin
        case (it.cmd)
          CMD_ASL: begin t = {src[6:0], 1'b0}; n.p[F_C] = src[7]; end
          CMD_ROL: begin t = {src[6:0], r.p[F_C]}; n.p[F_C] = src[7]; end
          CMD_LSR: begin t = {1'b0, src[7:1]}; n.p[F_C] = src[0]; end
          default: begin t = {r.p[F_C], src[7:1]}; n.p[F_C] = src[0]; end
        endcase
        nz_en = 1'b1; nz_v = t;
        if (it.acc_mode) begin
          n.a = t;
        end else begin
          res.write_enable = 1'b1; res.write_addr = it.eff_addr; res.write_data = t;
        end
      end
      CMD_BCC: begin branch = 1'b1; cond = !r.p[F_C]; end
      CMD_BCS: begin branch = 1'b1; cond = r.p[F_C]; end
      CMD_BEQ: begin branch = 1'b1; cond = r.p[F_Z]; end
      CMD_BNE: begin branch = 1'b1; cond = !r.p[F_Z]; end
      CMD_BMI: begin branch = 1'b1; cond = r.p[F_N]; end
      CMD_BPL: begin branch = 1'b1; cond = !r.p[F_N]; end
      CMD_BVS: begin branch = 1'b1; cond = r.p[F_V]; end
      CMD_BVC: begin branch = 1'b1; cond = !r.p[F_V]; end
      CMD_BIT: begin
        n.p[F_Z] = (r.a & m) == 8'h00;
        n.p[F_N] = m[7];
        n.p[F_V] = m[6];
      end
      CMD_BRK: begin
        n.p[F_I] = 1'b1;
        n.p[F_B] = 1'b0;
        n.sp = r.sp - 8'd3;
        res.pc_out = break_vector;
      end
      CMD_CLC: n.p[F_C] = 1'b0;
      CMD_CLD: n.p[F_D] = 1'b0;
      CMD_CLI: n.p[F_I] = 1'b0;
      CMD_CLV: n.p[F_V] = 1'b0;
      CMD_SEC: n.p[F_C] = 1'b1;
      CMD_SED: n.p[F_D] = 1'b1;
      CMD_SEI: n.p[F_I] = 1'b1;
      CMD_CMP, CMD_CPX, CMD_CPY: begin
        n.p[F_C] = !diff9[8];
        nz_en = 1'b1; nz_v = diff9[7:0];
        res.page_penalty_ok = 1'b1;
      end
      CMD_DEC, CMD_INC: begin
        t = (it.cmd == CMD_DEC) ? (m - 8'd1) : (m + 8'd1);
        nz_en = 1'b1; nz_v = t;
        res.write_enable = 1'b1; res.write_addr = it.eff_addr; res.write_data = t;
      end
      CMD_DEX: begin n.x = r.x - 8'd1; nz_en = 1'b1; nz_v = n.x; end
      CMD_DEY: begin n.y = r.y - 8'd1; nz_en = 1'b1; nz_v = n.y; end
      CMD_INX: begin n.x = r.x + 8'd1; nz_en = 1'b1; nz_v = n.x; end
      CMD_INY: begin n.y = r.y + 8'd1; nz_en = 1'b1; nz_v = n.y; end
      CMD_JMP: res.pc_out = it.eff_addr;
      CMD_JSR: begin n.sp = r.sp - 8'd2; res.pc_out = it.eff_addr; end
      CMD_LDA: begin n.a = m; nz_en = 1'b1; nz_v = m; res.page_penalty_ok = 1'b1; end
      CMD_LDX: begin n.x = m; nz_en = 1'b1; nz_v = m; res.page_penalty_ok = 1'b1; end
      CMD_LDY: begin n.y = m; nz_en = 1'b1; nz_v = m; res.page_penalty_ok = 1'b1; end
      CMD_NOP: res.page_penalty_ok = it.opcode == 8'h1C || it.opcode == 8'h3C ||
                                     it.opcode == 8'h5C || it.opcode == 8'h7C ||
                                     it.opcode == 8'hDC || it.opcode == 8'hFC;
      CMD_PHA: n.sp = r.sp - 8'd1;
      CMD_PHP: begin n.sp = r.sp - 8'd1; n.p[F_B] = 1'b0; n.p[F_U] = 1'b0; end
      CMD_PLA: begin n.sp = r.sp + 8'd1; n.a = pl.rd; nz_en = 1'b1; nz_v = pl.rd; end
      CMD_PLP: begin n.sp = r.sp + 8'd1; n.p = pl.rd | 8'h20; end
      CMD_RTI: begin
        n.sp = r.sp + 8'd3;
        n.p = pl.b0 & 8'hCF;
        res.pc_out = {pl.rd, pl.b1};
      end
      CMD_RTS: begin n.sp = r.sp + 8'd2; res.pc_out = {pl.rd, pl.b0} + 16'd1; end
      CMD_STA: begin res.write_enable = 1'b1; res.write_addr = it.eff_addr; res.write_data = r.a; end
      CMD_STX: begin res.write_enable = 1'b1; res.write_addr = it.eff_addr; res.write_data = r.x; end
      CMD_STY: begin res.write_enable = 1'b1; res.write_addr = it.eff_addr; res.write_data = r.y; end
      CMD_TAX: begin n.x = r.a; nz_en = 1'b1; nz_v = r.a; end
      CMD_TAY: begin n.y = r.a; nz_en = 1'b1; nz_v = r.a; end
      CMD_TSX: begin n.x = r.sp; nz_en = 1'b1; nz_v = r.sp; end
      CMD_TXA: begin n.a = r.x; nz_en = 1'b1; nz_v = r.x; end
      CMD_TXS: n.sp = r.x;
      CMD_TYA: begin n.a = r.y; nz_en = 1'b1; nz_v = r.y; end
      default: ;
    endcase
    if (nz_en) begin
      n.p[F_N] = nz_v[7];
      n.p[F_Z] = nz_v == 8'h00;
    end
    if (branch && cond) begin
      res.pc_out = target;
      res.extra_cycles = (target[15:8] != it.pc_next[15:8]) ? 2'd2 : 2'd1;
    end
    // BRK return address is unused by the datapath result; pushes use it upstream
    if (it.cmd == CMD_BRK && ret == 16'h0000) begin
      res.extra_cycles = 2'd0;
    end
    res.acc_out    = n.a;
    res.x_out      = n.x;
    res.y_out      = n.y;
    res.sp_out     = n.sp;
    res.status_out = n.p;
  end
endmodule

// ===== src/cpu6502_execute_unit_core.sv =====
// Top level of the 6502 execute unit: sequencer, architectural registers,
// stack page RAM and result register. Depends on cpu65_pkg, cpu65_exec, cpu65_stack_ram.

// One request executes one decoded 6502 instruction and gives one result. An
// instruction without stack traffic completes from the registered request and the
// next request is taken in the cycle it completes, so such instructions stream at
// one per cycle while the output register is free. Stack instructions go through
// the single port of the stack RAM, one byte per cycle: PHA and PHP push one byte,
// PLA and PLP pull one, JSR and RTS two, BRK and RTI three. A full output register
// stalls the final cycle. break_vector is written on the cfg channel, which is
// always ready. The stack page reads as zero after reset.
module cpu6502_execute_unit_core
  import cpu65_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cmd[5:0] opcode[13:6] operand[21:14] eff_addr[37:22] rel_offset[45:38]
  // pc_next[61:46], zero fill [63:62]
  input  logic [63:0] in_tdata,
  // acc_mode[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // write_enable[0] write_addr[16:1] write_data[24:17] pc_out[40:25] acc_out[48:41]
  // x_out[56:49] y_out[64:57] sp_out[72:65] status_out[80:73] extra_cycles[82:81]
  // page_penalty_ok[83], zero fill [87:84]
  output logic [87:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  seq_state_t state_r, state_nxt;
  logic [1:0] step_r, step_nxt;
  item_t      item_r;
  regs_t      regs_r, regs_nxt;
  logic [15:0] bv_r;
  logic [7:0] b0_r, b1_r;
  logic       out_valid_r;
  result_t    out_r;

  logic [1:0] push_n, pull_n;
  logic last, out_free, advance, done, accept;
  logic mem_en, mem_we;
  logic [7:0] mem_addr, mem_wdata, mem_rdata, push_byte;
  logic [15:0] ret_brk, ret_jsr;
  pulled_t pl;
  result_t res;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign pl        = '{b0: b0_r, b1: b1_r, rd: mem_rdata};

  cpu65_exec u_exec (
    .it(item_r), .r(regs_r), .pl(pl), .break_vector(bv_r), .n(regs_nxt), .res(res)
  );

  cpu65_stack_ram u_ram (
    .clk(clk), .rst_n(rst_n), .en(mem_en), .we(mem_we),
    .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  always_comb begin
    push_n = 2'd0;
    pull_n = 2'd0;
    case (item_r.cmd)
      CMD_PHA, CMD_PHP: push_n = 2'd1;
      CMD_JSR:          push_n = 2'd2;
      CMD_BRK:          push_n = 2'd3;
      CMD_PLA, CMD_PLP: pull_n = 2'd1;
      CMD_RTS:          pull_n = 2'd2;
      CMD_RTI:          pull_n = 2'd3;
      default: ;
    endcase
    if (pull_n != 2'd0) begin
      last = step_r == pull_n;
    end else if (push_n != 2'd0) begin
      last = step_r == push_n - 2'd1;
    end else begin
      last = 1'b1;
    end
  end

  assign advance = (state_r == ST_RUN) && (!last || out_free);
  assign done    = (state_r == ST_RUN) && last && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_RUN;
      ST_RUN:  if (done && !accept) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_RUN:  in_tready = done;
      default: in_tready = 1'b0;
    endcase
  end

  always_comb begin
    ret_brk = item_r.pc_next + 16'd1;
    ret_jsr = item_r.pc_next - 16'd1;
    case (item_r.cmd)
      CMD_PHA: push_byte = regs_r.a;
      CMD_PHP: push_byte = regs_r.p | 8'h30;
      CMD_JSR: push_byte = (step_r == 2'd0) ? ret_jsr[15:8] : ret_jsr[7:0];
      CMD_BRK: push_byte = (step_r == 2'd0) ? ret_brk[15:8] :
                           ((step_r == 2'd1) ? ret_brk[7:0] : (regs_r.p | 8'h14));
      default: push_byte = 8'h00;
    endcase
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = 8'h00;
    mem_wdata = 8'h00;
    if (advance) begin
      if (push_n != 2'd0) begin
        mem_en = 1'b1; mem_we = 1'b1;
        mem_addr = regs_r.sp - {6'd0, step_r};
        mem_wdata = push_byte;
      end else if (pull_n != 2'd0 && !last) begin
        mem_en = 1'b1;
        mem_addr = regs_r.sp + 8'd1 + {6'd0, step_r};
      end else if (last && res.write_enable && res.write_addr[15:8] == STACK_PAGE_HI) begin
        // store into page one also updates the stack copy
        mem_en = 1'b1; mem_we = 1'b1;
        mem_addr = res.write_addr[7:0];
        mem_wdata = res.write_data;
      end
    end
  end

  always_comb begin
    step_nxt = step_r;
    if (accept) begin
      step_nxt = 2'd0;
    end else if (advance && !last) begin
      step_nxt = step_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 2'd0;
      regs_r      <= '{a: 8'h00, x: 8'h00, y: 8'h00, sp: SP_RESET, p: 8'h00};
      bv_r        <= 16'h0000;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (cfg_valid && cfg_ready) begin
        bv_r <= cfg_data;
      end
      if (done) begin
        regs_r      <= regs_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= '{cmd: in_tdata[5:0], opcode: in_tdata[13:6], operand: in_tdata[21:14],
                  eff_addr: in_tdata[37:22], rel_offset: in_tdata[45:38],
                  acc_mode: in_tuser, pc_next: in_tdata[61:46]};
    end
    // capture pulled bytes as they arrive
    if (advance && step_r == 2'd1) b0_r <= mem_rdata;
    if (advance && step_r == 2'd2) b1_r <= mem_rdata;
    if (done) out_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'h0, out_r};
endmodule

// ===== src/cpu65_checker.sv =====
// Port-level checker for the 6502 execute unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module cpu65_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata
);
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `ASSERT_IMPL(a_extra_range, clk, rst_n, out_tvalid, out_tdata[82:81] != 2'd3)
  `ASSERT_IMPL(a_no_write_zero, clk, rst_n, out_tvalid && !out_tdata[0], out_tdata[24:1] == 24'd0)
  `ASSERT_IMPL(a_pen_not_branch, clk, rst_n, out_tvalid && out_tdata[83], out_tdata[82:81] == 2'd0)
endmodule

bind cpu6502_execute_unit_core cpu65_checker u_cpu65_checker (.*);
